>>> rtl/frm_pkg.sv
// Shared types, codes and constants of the serial frame receiver/checker.
// Used by frm_front, frm_back and the top level; depends on nothing.
package frm_pkg;

  // Default store depth in bytes
  localparam int FRAME_BYTES_DEF = 2048;

  // Fixed field widths
  localparam int RX_W   = 8;
  localparam int IDX_W  = 11;
  localparam int ST_W   = 3;
  localparam int LEN_W  = 12;

  // Header layout
  localparam int HDR_BYTES    = 10;
  localparam int TYPE_POS     = 4;
  localparam int SIZE_LO_POS  = 6;
  localparam int SIZE_HI_POS  = 7;
  localparam int DSUM_POS     = 8;
  localparam logic [RX_W-1:0] FRAME_TYPE = 8'hAA;

  // Receiver limit after reset
  localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd2048;

  // Queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_COLLECT  = 3'd0;
  localparam logic [ST_W-1:0] ST_GOOD     = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_HDR  = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_SUM  = 3'd3;
  localparam logic [ST_W-1:0] ST_TOO_LONG = 3'd4;
  localparam logic [ST_W-1:0] ST_READ     = 3'd5;

  // Classified operation
  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_OOR = 2'd2
  } frm_op_t;

  // Classified item between front and back
  typedef struct packed {
    frm_op_t          op;
    logic [RX_W-1:0]  rx_byte;
    logic [IDX_W-1:0] read_index;
  } frm_item_t;

  // One result transaction
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] frame_length;
    logic [RX_W-1:0]  read_byte;
  } frm_result_t;

endpackage

>>> rtl/frm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module frm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/frm_fifo.sv
// Small register-based FIFO with occupancy count.
// Standalone; no package dependency.
module frm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNTW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/frm_front.sv
// Front end: accepts input transactions and classifies them into operations.
// Depends on frm_pkg for the item type and operation codes.
module frm_front #(
  parameter int FRAME_BYTES = frm_pkg::FRAME_BYTES_DEF
) (
  input  logic                          func,
  input  logic [frm_pkg::RX_W-1:0]      rx_byte,
  input  logic [frm_pkg::IDX_W-1:0]     read_index,
  output frm_pkg::frm_item_t            item
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int RW = (CW > frm_pkg::IDX_W) ? CW : frm_pkg::IDX_W;

  logic [RW-1:0] idx_ext;
  logic          in_range;

  assign idx_ext  = RW'(read_index);
  assign in_range = (idx_ext < RW'(FRAME_BYTES));

  // Decode function and range of a read
  always_comb begin
    item.rx_byte    = rx_byte;
    item.read_index = read_index;
    if (!func) begin
      item.op = frm_pkg::OP_PUSH;
    end else if (in_range) begin
      item.op = frm_pkg::OP_READ;
    end else begin
      item.op = frm_pkg::OP_READ_OOR;
    end
  end

endmodule

>>> rtl/frm_back.sv
// Back end: runs the frame checker state, the frame store and the read path.
// Depends on frm_pkg, frm_ram.
module frm_back #(
  parameter int FRAME_BYTES = frm_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [frm_pkg::LEN_W-1:0]  cfg_data,
  input  logic                       item_valid,
  input  frm_pkg::frm_item_t         item,
  input  logic                       res_room,
  output logic                       item_take,
  output logic                       res_valid,
  output frm_pkg::frm_result_t       res
);

  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int XW  = (AW > frm_pkg::IDX_W) ? AW : frm_pkg::IDX_W;
  localparam int SZW = (CW > 16) ? CW : 16;
  localparam int LW  = (CW > frm_pkg::LEN_W) ? CW : frm_pkg::LEN_W;
  localparam int MAX_PAYLOAD = FRAME_BYTES - frm_pkg::HDR_BYTES;

  // Checker state
  logic [CW-1:0]               byte_count;
  logic [CW-1:0]               byte_count_next;
  logic [frm_pkg::RX_W-1:0]    header_sum;
  logic [frm_pkg::RX_W-1:0]    header_sum_next;
  logic [frm_pkg::RX_W-1:0]    payload_sum;
  logic [frm_pkg::RX_W-1:0]    payload_sum_next;
  logic [CW-1:0]               end_count;
  logic [CW-1:0]               end_count_next;
  logic [frm_pkg::RX_W-1:0]    type_byte;
  logic [frm_pkg::RX_W-1:0]    size_lo;
  logic [frm_pkg::RX_W-1:0]    size_hi;
  logic [frm_pkg::RX_W-1:0]    dsum_byte;
  logic [frm_pkg::LEN_W-1:0]   limit;

  // Execute-stage signals
  logic                        is_push;
  logic [CW-1:0]               count_inc;
  logic [15:0]                 size;
  logic                        at_hdr_end;
  logic                        in_payload;
  logic                        hdr_bad;
  logic [frm_pkg::RX_W-1:0]    psum_upd;
  logic [frm_pkg::RX_W-1:0]    psum_eff;
  logic                        done;
  logic                        too_long;
  logic                        drop;
  logic [LW-1:0]               len_ext;
  logic [frm_pkg::ST_W-1:0]    status_next;
  logic [frm_pkg::LEN_W-1:0]   flen_next;
  logic [XW-1:0]               idx_ext;
  logic                        ram_we;
  logic                        ram_re;
  logic [frm_pkg::RX_W-1:0]    ram_q;

  // Result stage
  logic [frm_pkg::ST_W-1:0]    r_status;
  logic [frm_pkg::LEN_W-1:0]   r_flen;
  logic                        r_hit;

  assign item_take = item_valid && res_room;
  assign is_push   = (item.op == frm_pkg::OP_PUSH);
  assign count_inc = byte_count + 1'b1;
  assign size      = {size_hi, size_lo};
  assign at_hdr_end = (byte_count == CW'(frm_pkg::HDR_BYTES - 1));
  assign in_payload = (byte_count >= CW'(frm_pkg::HDR_BYTES));
  assign psum_upd   = payload_sum + item.rx_byte;
  assign psum_eff   = in_payload ? psum_upd : payload_sum;
  assign len_ext    = LW'(count_inc);
  assign too_long   = (len_ext > LW'(limit));
  assign idx_ext    = XW'(item.read_index);

  // Check header at its last byte
  assign hdr_bad = (type_byte != frm_pkg::FRAME_TYPE) ||
                   (item.rx_byte != header_sum) ||
                   (SZW'(size) > SZW'(MAX_PAYLOAD));

  // Frame ends on the header byte for an empty payload, else on the last payload byte
  assign done = at_hdr_end ? (!hdr_bad && (size == 16'd0))
                           : (in_payload && (count_inc == end_count));
  assign drop = (at_hdr_end && hdr_bad) || done;

  // Classify outcome of the executed transaction
  always_comb begin
    status_next = frm_pkg::ST_COLLECT;
    flen_next   = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (item.op)
      frm_pkg::OP_PUSH: begin
        ram_we = item_take;
        if (at_hdr_end && hdr_bad) begin
          status_next = frm_pkg::ST_BAD_HDR;
        end else if (done) begin
          if (psum_eff != dsum_byte) begin
            status_next = frm_pkg::ST_BAD_SUM;
          end else if (too_long) begin
            status_next = frm_pkg::ST_TOO_LONG;
          end else begin
            status_next = frm_pkg::ST_GOOD;
            flen_next   = len_ext[frm_pkg::LEN_W-1:0];
          end
        end
      end
      frm_pkg::OP_READ: begin
        status_next = frm_pkg::ST_READ;
        ram_re      = item_take;
      end
      default: begin
        status_next = frm_pkg::ST_READ;
      end
    endcase
  end

  // Next checker state for a pushed byte
  always_comb begin
    byte_count_next  = count_inc;
    header_sum_next  = header_sum;
    payload_sum_next = payload_sum;
    end_count_next   = end_count;
    if (byte_count < CW'(frm_pkg::HDR_BYTES - 1)) begin
      header_sum_next = header_sum + item.rx_byte;
    end
    if (in_payload) begin
      payload_sum_next = psum_upd;
    end
    if (at_hdr_end) begin
      end_count_next = CW'(frm_pkg::HDR_BYTES) + CW'(size);
    end
    if (drop) begin
      byte_count_next  = '0;
      header_sum_next  = '0;
      payload_sum_next = '0;
    end
  end

  // Hold checker state and receiver limit
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      header_sum  <= '0;
      payload_sum <= '0;
      end_count   <= CW'(frm_pkg::HDR_BYTES);
      limit       <= frm_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (item_take && is_push) begin
        byte_count  <= byte_count_next;
        header_sum  <= header_sum_next;
        payload_sum <= payload_sum_next;
        end_count   <= end_count_next;
      end
    end
  end

  // Capture header fields as they arrive
  always_ff @(posedge clk) begin
    if (item_take && is_push) begin
      if (byte_count == CW'(frm_pkg::TYPE_POS)) begin
        type_byte <= item.rx_byte;
      end
      if (byte_count == CW'(frm_pkg::SIZE_LO_POS)) begin
        size_lo <= item.rx_byte;
      end
      if (byte_count == CW'(frm_pkg::SIZE_HI_POS)) begin
        size_hi <= item.rx_byte;
      end
      if (byte_count == CW'(frm_pkg::DSUM_POS)) begin
        dsum_byte <= item.rx_byte;
      end
    end
  end

  // Frame store
  frm_ram #(
    .WIDTH (frm_pkg::RX_W),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (item.rx_byte),
    .re    (ram_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_q)
  );

  // Result stage lines up with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= item_take;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      r_status <= status_next;
      r_flen   <= flen_next;
      r_hit    <= (item.op == frm_pkg::OP_READ);
    end
  end

  assign res.status       = r_status;
  assign res.frame_length = r_flen;
  assign res.read_byte    = r_hit ? ram_q : '0;

endmodule

>>> rtl/serial_frame_receiver_checker.sv
// Top level of the serial frame receiver/checker.
// Depends on frm_pkg, frm_front, frm_fifo, frm_back (and frm_ram below it).

// Queue-style receiver: push bytes (func 0) or read the frame store (func 1);
// every input transaction yields exactly one result transaction, in order.
// The block takes one transaction per clock while full is low and returns one per
// clock when pop is held; a result passes through the classify queue, the execute
// stage with its registered store read and the output queue before it can be
// popped. The sustained rate is set by the back end, which executes one
// transaction per cycle with at most one store access each while the output queue
// has room. No clearing pass runs after reset: the store is usable at once, and
// bytes never written read back as undefined.
// receiver_limit is written through cfg_write/cfg_data and must only change
// while no transaction is in flight.
module serial_frame_receiver_checker #(
  parameter int FRAME_BYTES = frm_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       func,
  input  logic [frm_pkg::RX_W-1:0]   rx_byte,
  input  logic [frm_pkg::IDX_W-1:0]  read_index,
  output logic                       empty,
  input  logic                       pop,
  output logic [frm_pkg::ST_W-1:0]   status,
  output logic [frm_pkg::LEN_W-1:0]  frame_length,
  output logic [frm_pkg::RX_W-1:0]   read_byte,
  input  logic                       cfg_write,
  input  logic [frm_pkg::LEN_W-1:0]  cfg_data
);

  localparam int IW   = $bits(frm_pkg::frm_item_t);
  localparam int OW   = $bits(frm_pkg::frm_result_t);
  localparam int MCW  = $clog2(frm_pkg::MID_DEPTH + 1);
  localparam int OCW  = $clog2(frm_pkg::OUT_DEPTH + 1);

  frm_pkg::frm_item_t    front_item;
  frm_pkg::frm_item_t    mid_item;
  logic [IW-1:0]         mid_rdata;
  logic                  mid_empty;
  logic [MCW-1:0]        mid_count;
  logic                  item_take;
  logic                  res_valid;
  frm_pkg::frm_result_t  res;
  frm_pkg::frm_result_t  out_res;
  logic [OW-1:0]         out_rdata;
  logic                  out_full;
  logic [OCW-1:0]        out_count;
  logic                  res_room;

  // Classify incoming transactions
  frm_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .func       (func),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .item       (front_item)
  );

  // Decouple front from back
  frm_fifo #(
    .WIDTH (IW),
    .DEPTH (frm_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (item_take),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign mid_item = frm_pkg::frm_item_t'(mid_rdata);

  // Reserve a result slot for the transaction in the result stage
  assign res_room = ((OCW + 1)'(out_count) + (OCW + 1)'(res_valid))
                    < (OCW + 1)'(frm_pkg::OUT_DEPTH);

  // Execute against checker state and frame store
  frm_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (!mid_empty),
    .item       (mid_item),
    .res_room   (res_room),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Hold results until popped
  frm_fifo #(
    .WIDTH (OW),
    .DEPTH (frm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign out_res      = frm_pkg::frm_result_t'(out_rdata);
  assign status       = out_res.status;
  assign frame_length = out_res.frame_length;
  assign read_byte    = out_res.read_byte;

  // Result stage never finds the output queue full
  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_full)
    else $error("result dropped: output queue full");

  // Classify queue count stays within its depth
  a_mid_bound: assert property (@(posedge clk) disable iff (rst)
    mid_count <= MCW'(frm_pkg::MID_DEPTH))
    else $error("classify queue count out of range");

  // Only a good frame carries a length, and it covers at least the header
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != frm_pkg::ST_GOOD) |-> (frame_length == '0))
    else $error("length on a result that is not a good frame");

  a_len_min: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == frm_pkg::ST_GOOD) |->
      (frame_length >= frm_pkg::LEN_W'(frm_pkg::HDR_BYTES)))
    else $error("good frame shorter than its header");

  // Only a read reply carries store data
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != frm_pkg::ST_READ) |-> (read_byte == '0))
    else $error("store data on a result that is not a read reply");

endmodule
